@@ rtl/wide_by_scalar_mul_div_assert.svh @@
// assertion macros for the wide-by-scalar multiply/divide block
// needs clk and rst_n in the scope where a macro is used
`ifndef WIDE_BY_SCALAR_MUL_DIV_ASSERT_SVH
`define WIDE_BY_SCALAR_MUL_DIV_ASSERT_SVH

// same-cycle implication
`define WSMD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WSMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/wsmd_pkg.sv @@
// shared types and constants of the wide-by-scalar multiply/divide block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wsmd_pkg;

  localparam int LIMB_W = 64;
  localparam int CNT_W  = 6;

  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DONE
  } wsmd_state_t;

  typedef struct packed {
    logic load;
    logic first;
    logic dz;
    logic step;
    logic op;
  } wsmd_ctl_t;

endpackage

`default_nettype wire

@@ rtl/wsmd_in_if.sv @@
// request channel: valid/ready with operation, operand limb and scalar
// depends on wsmd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface wsmd_in_if;
  import wsmd_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [LIMB_W-1:0] limb_in;
  logic [LIMB_W-1:0] scalar;

  modport source (output valid, output req_type, output limb_in, output scalar,
                  input ready);
  modport sink (input valid, input req_type, input limb_in, input scalar,
                output ready);
endinterface

`default_nettype wire

@@ rtl/wsmd_out_if.sv @@
// result channel: valid/ready with result limb, last and divide-by-zero flag
// depends on wsmd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface wsmd_out_if;
  import wsmd_pkg::*;

  logic              valid;
  logic              ready;
  logic [LIMB_W-1:0] limb_out;
  logic              last;
  logic              div_zero;

  modport source (output valid, output limb_out, output last, output div_zero,
                  input ready);
  modport sink (input valid, input limb_out, input last, input div_zero,
                output ready);
endinterface

`default_nettype wire

@@ rtl/wide_by_scalar_mul_div.sv @@
// Wide-by-scalar multiply/divide: a LIMBS x 64-bit number times or divided by a 64-bit scalar.
// Request channel in_ch: one 64-bit limb per request. req_type and scalar are taken at the
//   first limb of each number and held for the rest; multiply sends the least significant
//   limb first, divide the most significant limb first.
// Result channel out_ch: one result limb per request, in the same order, with last on the
//   final limb and div_zero on every limb of a divide by zero (limb_out then all ones).
// Each limb goes through one bit-serial shift-add / restoring-divide unit, one bit a cycle:
//   a limb is accepted, stepped through each of its bits, and then written to the output
//   register once that is free; the block takes no new limb before the current one is
//   written. A divide-by-zero limb skips the unit and goes straight to the output register.
// The block works on one limb at a time; in_ch.ready is high while the unit is free, even
//   when a result still waits in the output register.
// If the receiver stalls, the finished limb waits in the unit until the output register
//   frees up; no limb is lost and the next request is held off meanwhile.
// Reset (rst_n, synchronous, active low) empties the output register, stops any limb in
//   work and restarts number framing at the first limb.
`timescale 1ns / 1ps
`default_nettype none

module wide_by_scalar_mul_div #(
  parameter int LIMBS = 4
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  wsmd_in_if.sink     in_ch,
  wsmd_out_if.source  out_ch
);
  import wsmd_pkg::*;

  wsmd_ctl_t         ctl;
  logic              out_load;
  logic              slot_free;
  logic              last;
  logic              dz;
  logic              scalar_zero;
  logic [LIMB_W-1:0] res;

  logic              out_valid_r, out_valid_nxt;
  logic [LIMB_W-1:0] out_limb_r, out_limb_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_dz_r, out_dz_nxt;

  assign scalar_zero = (in_ch.scalar == '0);
  assign slot_free   = !out_valid_r || out_ch.ready;

  wsmd_ctrl #(
    .LIMBS(LIMBS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .req_type   (in_ch.req_type),
    .scalar_zero(scalar_zero),
    .slot_free  (slot_free),
    .in_ready   (in_ch.ready),
    .out_load   (out_load),
    .last       (last),
    .dz         (dz),
    .ctl        (ctl)
  );

  wsmd_serial_unit u_unit (
    .clk   (clk),
    .ctl   (ctl),
    .limb  (in_ch.limb_in),
    .scalar(in_ch.scalar),
    .res   (res)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_limb_nxt  = out_limb_r;
    out_last_nxt  = out_last_r;
    out_dz_nxt    = out_dz_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_limb_nxt  = dz ? '1 : res;
      out_last_nxt  = last;
      out_dz_nxt    = dz;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_limb_r <= out_limb_nxt;
    out_last_r <= out_last_nxt;
    out_dz_r   <= out_dz_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.limb_out = out_limb_r;
  assign out_ch.last     = out_last_r;
  assign out_ch.div_zero = out_dz_r;

endmodule

`default_nettype wire

@@ rtl/wsmd_serial_unit.sv @@
// bit-serial datapath: shift-add multiply and restoring divide, one bit a cycle
// depends on wsmd_pkg; the high register carries the carry/remainder across limbs
`timescale 1ns / 1ps
`default_nettype none

module wsmd_serial_unit (
  input  wire logic                        clk,
  input  wire wsmd_pkg::wsmd_ctl_t         ctl,
  input  wire logic [wsmd_pkg::LIMB_W-1:0] limb,
  input  wire logic [wsmd_pkg::LIMB_W-1:0] scalar,
  output logic      [wsmd_pkg::LIMB_W-1:0] res
);
  import wsmd_pkg::*;

  logic [LIMB_W-1:0] hi_r, hi_nxt;
  logic [LIMB_W-1:0] lo_r, lo_nxt;
  logic [LIMB_W-1:0] scalar_r, scalar_nxt;
  logic [LIMB_W:0]   mul_sum;
  logic [LIMB_W:0]   div_rem;
  logic [LIMB_W+1:0] div_diff;
  logic              div_ge;

  always_comb begin
    mul_sum  = {1'b0, hi_r} + (lo_r[0] ? {1'b0, scalar_r} : '0);
    div_rem  = {hi_r, lo_r[LIMB_W-1]};
    div_diff = {1'b0, div_rem} - {2'b00, scalar_r};
    div_ge   = ~div_diff[LIMB_W+1];
  end

  always_comb begin
    hi_nxt     = hi_r;
    lo_nxt     = lo_r;
    scalar_nxt = scalar_r;
    if (ctl.load) begin
      lo_nxt = limb;
      if (ctl.first) begin
        scalar_nxt = scalar;
      end
      if (ctl.first || ctl.dz) begin
        hi_nxt = '0;
      end
    end else if (ctl.step) begin
      if (ctl.op == OP_MUL) begin
        hi_nxt = mul_sum[LIMB_W:1];
        lo_nxt = {mul_sum[0], lo_r[LIMB_W-1:1]};
      end else begin
        hi_nxt = div_ge ? div_diff[LIMB_W-1:0] : div_rem[LIMB_W-1:0];
        lo_nxt = {lo_r[LIMB_W-2:0], div_ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    hi_r     <= hi_nxt;
    lo_r     <= lo_nxt;
    scalar_r <= scalar_nxt;
  end

  assign res = lo_r;

endmodule

`default_nettype wire

@@ rtl/wsmd_ctrl.sv @@
// sequencer: request handshake, bit counter, limb index and held operation
// depends on wsmd_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

module wsmd_ctrl #(
  parameter int LIMBS = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                req_type,
  input  wire logic                scalar_zero,
  input  wire logic                slot_free,
  output logic                     in_ready,
  output logic                     out_load,
  output logic                     last,
  output logic                     dz,
  output wsmd_pkg::wsmd_ctl_t      ctl
);
  import wsmd_pkg::*;

  localparam int IDX_W = (LIMBS > 1) ? $clog2(LIMBS) : 1;

  wsmd_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              op_r, op_nxt;
  logic              dz_r, dz_nxt;
  logic              first;
  logic              accept;
  logic              cnt_end;

  assign first   = (idx_r == '0);
  assign last    = (idx_r == IDX_W'(LIMBS - 1));
  assign accept  = in_valid && in_ready;
  assign cnt_end = (cnt_r == CNT_W'(LIMB_W - 1));
  assign op_nxt  = (accept && first) ? req_type : op_r;
  assign dz_nxt  = (accept && first) ? (req_type && scalar_zero) : dz_r;
  assign dz      = dz_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = dz_nxt ? S_DONE : S_CALC;
        end
      end
      S_CALC: begin
        if (cnt_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    ctl.load  = 1'b0;
    ctl.step  = 1'b0;
    ctl.first = first;
    ctl.dz    = dz_nxt;
    ctl.op    = op_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        ctl.load = accept;
      end
      S_CALC: begin
        ctl.step = 1'b1;
      end
      S_DONE: begin
        out_load = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = (state_r == S_CALC) ? cnt_r + CNT_W'(1) : '0;
    idx_nxt = idx_r;
    if (out_load) begin
      idx_nxt = last ? '0 : idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      op_r    <= OP_MUL;
      dz_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      op_r    <= op_nxt;
      dz_r    <= dz_nxt;
    end
  end

`include "wide_by_scalar_mul_div_assert.svh"

  `WSMD_ASSERT_NOW(a_dz_only_div, dz_r, op_r == OP_DIV, "div_zero set outside a divide")
  `WSMD_ASSERT_NOW(a_no_load_idle, in_ready, !out_load, "result loaded while taking a request")
  `WSMD_ASSERT_NEXT(a_load_then_idle, out_load, in_ready, "block not ready after result load")
  `WSMD_ASSERT_NEXT(a_dz_skips_calc, accept && dz_nxt, state_r == S_DONE, "zero divisor ran the unit")

endmodule

`default_nettype wire
